// ===== hdl/viewport_aspect_fit_macros.svh =====
// Assertion macros shared by the viewport fit design.
`ifndef VIEWPORT_ASPECT_FIT_MACROS_SVH
`define VIEWPORT_ASPECT_FIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define VAF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define VAF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vaf_pkg.sv =====
// Package with widths, mode codes and pipeline context for the viewport fit design.
`default_nettype none
package vaf_pkg;
	localparam int DIM_W  = 13;
	localparam int NUM_W  = 2 * DIM_W;
	localparam int DEN_W  = DIM_W + 1;
	localparam int OUT_W  = 14;
	localparam int IN_W   = ((4 * DIM_W + 7) / 8) * 8;
	localparam int OUTD_W = ((4 * OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		MODE_FULL    = 2'd0,
		MODE_4X3     = 2'd1,
		MODE_CONTENT = 2'd2,
		MODE_INTEGER = 2'd3
	} mode_t;

	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] cw;
		logic [DIM_W-1:0] ch;
		mode_t            mode;
		logic             flag;
	} ctx_t;
endpackage
`default_nettype wire

// ===== hdl/vaf_prep.sv =====
// First stage: chooses dividends and divisors for the two dividers by fit mode.
`default_nettype none
module vaf_prep
	import vaf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [DIM_W-1:0] sw,
	input  wire logic [DIM_W-1:0] sh,
	input  wire logic [DIM_W-1:0] cw,
	input  wire logic [DIM_W-1:0] ch,
	input  wire mode_t            mode,
	output logic                  valid_s1,
	output logic [NUM_W-1:0]      num_a_s1,
	output logic [DEN_W-1:0]      den_a_s1,
	output logic [NUM_W-1:0]      num_b_s1,
	output logic [DEN_W-1:0]      den_b_s1,
	output ctx_t                  ctx_s1
);
	logic [NUM_W-1:0] num_a, num_b;
	logic [DEN_W-1:0] den_a, den_b;
	logic             zero;

	always_comb begin
		zero  = (cw == '0) || (ch == '0);
		num_a = '0;
		num_b = '0;
		den_a = DEN_W'(1);
		den_b = DEN_W'(1);
		case (mode)
			MODE_4X3: begin
				num_a = NUM_W'(sh) * NUM_W'(4);
				den_a = DEN_W'(3 * 2);
				num_b = NUM_W'(sw) * NUM_W'(3);
				den_b = DEN_W'(4 * 2);
			end
			MODE_CONTENT: begin
				if (!zero) begin
					num_a = NUM_W'(sh) * NUM_W'(cw);
					den_a = {ch, 1'b0};
					num_b = NUM_W'(sw) * NUM_W'(ch);
					den_b = {cw, 1'b0};
				end
			end
			MODE_INTEGER: begin
				if (!zero) begin
					num_a = NUM_W'(sw);
					den_a = DEN_W'(cw);
					num_b = NUM_W'(sh);
					den_b = DEN_W'(ch);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_a_s1     <= num_a;
			den_a_s1     <= den_a;
			num_b_s1     <= num_b;
			den_b_s1     <= den_b;
			ctx_s1.sw    <= sw;
			ctx_s1.sh    <= sh;
			ctx_s1.cw    <= cw;
			ctx_s1.ch    <= ch;
			ctx_s1.mode  <= mode;
			ctx_s1.flag  <= zero && (mode == MODE_CONTENT || mode == MODE_INTEGER);
		end
	end
endmodule
`default_nettype wire

// ===== hdl/vaf_div.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage, with context.
`default_nettype none
module vaf_div
	import vaf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num_a,
	input  wire logic [DEN_W-1:0] den_a,
	input  wire logic [NUM_W-1:0] num_b,
	input  wire logic [DEN_W-1:0] den_b,
	input  wire ctx_t             in_ctx,
	output logic                  out_valid,
	output logic [NUM_W-1:0]      q_a,
	output logic [NUM_W-1:0]      q_b,
	output ctx_t                  out_ctx
);
	logic [NUM_W-1:0] dq_s  [0:NUM_W][0:1];
	logic [DEN_W-1:0] rem_s [0:NUM_W][0:1];
	logic [DEN_W-1:0] den_s [0:NUM_W][0:1];
	ctx_t             ctx_s [0:NUM_W];
	logic             vld_s [0:NUM_W];

	assign dq_s[0][0]  = num_a;
	assign dq_s[0][1]  = num_b;
	assign den_s[0][0] = den_a;
	assign den_s[0][1] = den_b;
	assign rem_s[0][0] = '0;
	assign rem_s[0][1] = '0;
	assign ctx_s[0]    = in_ctx;
	assign vld_s[0]    = in_valid;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[k+1] <= ctx_s[k];
			end
		end

		for (genvar l = 0; l < 2; l++) begin : g_lane
			logic [DEN_W:0] trial;
			logic           ge;

			always_comb begin
				trial = {rem_s[k][l], dq_s[k][l][NUM_W-1]};
				ge    = trial >= {1'b0, den_s[k][l]};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k+1][l] <= den_s[k][l];
					dq_s[k+1][l]  <= {dq_s[k][l][NUM_W-2:0], ge};
					rem_s[k+1][l] <= ge ? DEN_W'(trial - {1'b0, den_s[k][l]}) : trial[DEN_W-1:0];
				end
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign q_a       = dq_s[NUM_W][0];
	assign q_b       = dq_s[NUM_W][1];
	assign out_ctx   = ctx_s[NUM_W];
endmodule
`default_nettype wire

// ===== hdl/vaf_post.sv =====
// Back end: integer scale selection and multiply, then rectangle assembly.
`default_nettype none
module vaf_post
	import vaf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] q_a,
	input  wire logic [NUM_W-1:0] q_b,
	input  wire ctx_t             in_ctx,
	output logic                  valid_s3,
	output logic [OUT_W-1:0]      x_s3,
	output logic [OUT_W-1:0]      y_s3,
	output logic [OUT_W-1:0]      w_s3,
	output logic [OUT_W-1:0]      h_s3,
	output logic                  flag_s3
);
	localparam int AW = NUM_W + 2;

	logic             valid_s1, valid_s2;
	logic [NUM_W-1:0] qa_s1, qb_s1, qa_s2, qb_s2;
	logic [DIM_W-1:0] ratio_s1;
	logic [NUM_W-1:0] pw_s2, ph_s2;
	ctx_t             ctx_s1, ctx_s2;

	logic [AW-1:0] hw, hh, qa, qb, pw, ph, xv, yv, wv, hv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qa_s1    <= q_a;
			qb_s1    <= q_b;
			ctx_s1   <= in_ctx;
			ratio_s1 <= (q_b < q_a) ? q_b[DIM_W-1:0] : q_a[DIM_W-1:0];
			qa_s2    <= qa_s1;
			qb_s2    <= qb_s1;
			ctx_s2   <= ctx_s1;
			pw_s2    <= NUM_W'(ctx_s1.cw) * NUM_W'(ratio_s1);
			ph_s2    <= NUM_W'(ctx_s1.ch) * NUM_W'(ratio_s1);
		end
	end

	always_comb begin
		hw = AW'(ctx_s2.sw >> 1);
		hh = AW'(ctx_s2.sh >> 1);
		qa = AW'(qa_s2);
		qb = AW'(qb_s2);
		pw = AW'(pw_s2 >> 1);
		ph = AW'(ph_s2 >> 1);
		xv = '0;
		yv = '0;
		wv = AW'(ctx_s2.sw);
		hv = AW'(ctx_s2.sh);
		if (!ctx_s2.flag) begin
			case (ctx_s2.mode)
				MODE_4X3, MODE_CONTENT: begin
					if (qa > hw) begin
						yv = hh - qb;
						hv = qb + qb;
					end else begin
						xv = hw - qa;
						wv = qa + qa;
					end
				end
				MODE_INTEGER: begin
					xv = hw - pw;
					wv = pw + pw;
					yv = hh - ph;
					hv = ph + ph;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= xv[OUT_W-1:0];
			y_s3    <= yv[OUT_W-1:0];
			w_s3    <= wv[OUT_W-1:0];
			h_s3    <= hv[OUT_W-1:0];
			flag_s3 <= ctx_s2.flag;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/viewport_aspect_fit.sv =====
// Top level of the viewport fit block: stream ports, mode register and pipeline.
// Each beat carries a window size and a content size and yields one centered
// destination rectangle for the current fit mode. The pipeline takes one beat
// per clock unless stalled and has one setup stage, 26 stages of the two
// restoring dividers (one quotient bit each), and three back-end stages.
// A result that is not taken holds the whole pipeline, so the input stalls only
// while the output is full and not ready. Write fit_mode only while idle.
`default_nettype none
module viewport_aspect_fit
	import vaf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// window_width, window_height, content_width, content_height, zero fill
	input  wire logic [IN_W-1:0]   s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// out_x, out_y, out_width, out_height
	output logic [OUTD_W-1:0]      m_tdata,
	// zero_divisor
	output logic [0:0]             m_tuser
);
	mode_t            mode_q;
	logic             en;
	logic             valid_s1, div_valid;
	logic [NUM_W-1:0] num_a_s1, num_b_s1, q_a, q_b;
	logic [DEN_W-1:0] den_a_s1, den_b_s1;
	ctx_t             ctx_s1, div_ctx;
	logic [OUT_W-1:0] x, y, w, h;
	logic             flag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FULL;
		end else if (cfg_we) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	assign en       = !(m_tvalid && !m_tready);
	assign s_tready = en;

	vaf_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.sw       (s_tdata[DIM_W-1:0]),
		.sh       (s_tdata[2*DIM_W-1:DIM_W]),
		.cw       (s_tdata[3*DIM_W-1:2*DIM_W]),
		.ch       (s_tdata[4*DIM_W-1:3*DIM_W]),
		.mode     (mode_q),
		.valid_s1 (valid_s1),
		.num_a_s1 (num_a_s1),
		.den_a_s1 (den_a_s1),
		.num_b_s1 (num_b_s1),
		.den_b_s1 (den_b_s1),
		.ctx_s1   (ctx_s1)
	);

	vaf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.num_a     (num_a_s1),
		.den_a     (den_a_s1),
		.num_b     (num_b_s1),
		.den_b     (den_b_s1),
		.in_ctx    (ctx_s1),
		.out_valid (div_valid),
		.q_a       (q_a),
		.q_b       (q_b),
		.out_ctx   (div_ctx)
	);

	vaf_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_valid),
		.q_a      (q_a),
		.q_b      (q_b),
		.in_ctx   (div_ctx),
		.valid_s3 (m_tvalid),
		.x_s3     (x),
		.y_s3     (y),
		.w_s3     (w),
		.h_s3     (h),
		.flag_s3  (flag)
	);

	assign m_tdata = OUTD_W'({h, w, y, x});
	assign m_tuser = flag;

`include "viewport_aspect_fit_macros.svh"

	`VAF_ASSERT_NOW(a_flag_origin, m_tvalid && m_tuser[0], x == '0 && y == '0, "flagged result not at origin")
	`VAF_ASSERT_NOW(a_full_origin, m_tvalid && mode_q == MODE_FULL, x == '0 && y == '0 && !flag, "full mode result off origin")
	`VAF_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
endmodule
`default_nettype wire
